// ----- src/dlt_pkg.sv -----
// ----------------------------------------------------------------------------
// dlt_pkg
// Shared constants, status codes and control/status bundles for the
// DL/T 645 frame receiver.
// ----------------------------------------------------------------------------
package dlt_pkg;

    localparam int BUFFER_BYTES_DEF = 64;
    localparam int MAX_RESULTS      = 52;
    localparam int HEADER_BYTES     = 10;
    localparam int FRAME_OVERHEAD   = HEADER_BYTES + 2;

    localparam logic [7:0] START_BYTE  = 8'h68;
    localparam logic [7:0] END_BYTE    = 8'h16;
    localparam logic [7:0] DATA_OFFSET = 8'h33;

    localparam int OUT_TDATA_W = 80;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_END  = 2'd1;
    localparam logic [1:0] STATUS_BAD_SUM  = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic       store;        // received byte accepted
        logic       close;        // frame finished, rewind counters
        logic       load_status;  // load a single-result status item
        logic [1:0] status_code;
        logic       issue_read;   // read next data byte from the store
        logic       load_data;    // load a decoded data item
    } dlt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;   // output register can take a new item this cycle
        logic complete;   // current byte closes the frame at expected size
        logic overflow;   // current byte fills the buffer before completion
        logic bad_end;
        logic bad_sum;
        logic len_zero;
        logic last_idx;   // data item under read is the final one
    } dlt_stat_t;

endpackage

// ----- src/dlt_ctrl.sv -----
// ----------------------------------------------------------------------------
// dlt_ctrl
// Frame receiver sequencer: byte intake, outcome decision, data drain.
// ----------------------------------------------------------------------------
module dlt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dlt_pkg::dlt_stat_t stat,
    output dlt_pkg::dlt_cmd_t  cmd,
    output logic              busy
);
    import dlt_pkg::*;

    typedef enum logic [1:0] {
        S_RECV,
        S_READ,
        S_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_RECV) && stat.out_free;
    assign accept   = in_valid && in_ready;
    assign busy     = (state_reg != S_RECV);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_RECV:
            begin
                if (accept)
                begin
                    cmd.store = 1'b1;
                    if (stat.complete)
                    begin
                        cmd.close = 1'b1;
                        if (stat.bad_end)
                        begin
                            cmd.load_status = 1'b1;
                            cmd.status_code = STATUS_BAD_END;
                        end
                        else if (stat.bad_sum)
                        begin
                            cmd.load_status = 1'b1;
                            cmd.status_code = STATUS_BAD_SUM;
                        end
                        else if (stat.len_zero)
                        begin
                            cmd.load_status = 1'b1;
                            cmd.status_code = STATUS_OK;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    else if (stat.overflow)
                    begin
                        cmd.close       = 1'b1;
                        cmd.load_status = 1'b1;
                        cmd.status_code = STATUS_OVERFLOW;
                    end
                end
            end
            S_READ:
            begin
                if (stat.out_free)
                begin
                    cmd.issue_read = 1'b1;
                    state_next     = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_data = 1'b1;
                state_next    = stat.last_idx ? S_RECV : S_READ;
            end
            default:
            begin
                state_next = S_RECV;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RECV;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/dlt_datapath.sv -----
// ----------------------------------------------------------------------------
// dlt_datapath
// Frame store, byte counter, running checksum, header capture and the
// output register.
// ----------------------------------------------------------------------------
module dlt_datapath #(
    parameter int BUFFER_BYTES = dlt_pkg::BUFFER_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [7:0]                     rx_byte,
    input  dlt_pkg::dlt_cmd_t              cmd,
    output dlt_pkg::dlt_stat_t             stat,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [1:0]                     out_status,
    output logic [dlt_pkg::OUT_TDATA_W-1:0] out_data,
    output logic                           out_last
);
    import dlt_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);

    logic [7:0]    mem [0:BUFFER_BYTES-1];
    logic [7:0]    rd_data_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [7:0]    sum_reg;
    logic [7:0]    prev_reg;
    logic [47:0]   addr_reg;
    logic [7:0]    ctrl_reg;
    logic [7:0]    len_reg;
    logic [5:0]    idx_reg;

    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [7:0]    out_byte_reg;
    logic [5:0]    out_index_reg;
    logic          out_last_reg;

    logic          open_frame;
    logic          evaluate;
    logic [8:0]    expected;
    logic [7:0]    sum_before_cs;
    logic [5:0]    last_index;
    logic [6:0]    rd_sum;

    assign open_frame    = (count_reg != '0) || (rx_byte == START_BYTE);
    assign count_next    = count_reg + CW'(1);
    assign evaluate      = count_reg >= CW'(HEADER_BYTES);
    assign expected      = 9'(FRAME_OVERHEAD) + {1'b0, len_reg};
    assign sum_before_cs = sum_reg - prev_reg;
    assign last_index    = (len_reg > 8'(MAX_RESULTS)) ? 6'(MAX_RESULTS - 1)
                                                       : (len_reg[5:0] - 6'd1);
    assign rd_sum        = 7'(HEADER_BYTES) + {1'b0, idx_reg};

    always_comb
    begin
        stat.out_free = !out_valid_reg || out_ready;
        stat.complete = evaluate && (9'(count_next) == expected);
        stat.overflow = evaluate && (9'(count_next) != expected)
                        && (count_next == CW'(BUFFER_BYTES));
        stat.bad_end  = rx_byte != END_BYTE;
        stat.bad_sum  = sum_before_cs != prev_reg;
        stat.len_zero = len_reg == 8'd0;
        stat.last_idx = idx_reg == last_index;
    end

    // frame store, no reset: only entries written in the current frame are read
    always_ff @(posedge clk)
    begin
        if (cmd.store && open_frame)
        begin
            mem[count_reg[AW-1:0]] <= rx_byte;
        end
        if (cmd.issue_read)
        begin
            rd_data_reg <= mem[rd_sum[AW-1:0]];
        end
    end

    // header copies and previous byte
    always_ff @(posedge clk)
    begin
        if (cmd.store && open_frame)
        begin
            prev_reg <= rx_byte;
            for (int k = 0; k < 6; k++)
            begin
                if (count_reg == CW'(k + 1))
                begin
                    addr_reg[k*8 +: 8] <= rx_byte;
                end
            end
            if (count_reg == CW'(8))
            begin
                ctrl_reg <= rx_byte;
            end
            if (count_reg == CW'(9))
            begin
                len_reg <= rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.close)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                idx_reg   <= '0;
            end
            else
            begin
                if (cmd.store && open_frame)
                begin
                    count_reg <= count_next;
                    sum_reg   <= sum_reg + rx_byte;
                end
                if (cmd.load_data)
                begin
                    idx_reg <= idx_reg + 6'd1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_status || cmd.load_data)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_status)
        begin
            out_status_reg <= cmd.status_code;
            out_byte_reg   <= 8'd0;
            out_index_reg  <= 6'd0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.load_data)
        begin
            out_status_reg <= STATUS_OK;
            out_byte_reg   <= rd_data_reg - DATA_OFFSET;
            out_index_reg  <= idx_reg;
            out_last_reg   <= stat.last_idx;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;
    assign out_data   = {2'b00, addr_reg, ctrl_reg, len_reg, out_index_reg, out_byte_reg};

endmodule

// ----- src/dlt645_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// dlt645_frame_receiver
// DL/T 645-2007 frame receiver: hunts for the start byte, stores the frame,
// checks end marker and checksum, and emits decoded data bytes or a status.
// ----------------------------------------------------------------------------
//
//  channel  dir  fields (low bit up)                                   frame mark
//  s_*      in   tdata: rx_byte[7:0]                                   -
//  m_*      out  tdata: data_byte, byte_index, data_length,            tlast =
//                control_code, meter_address, 2 pad; tuser: status     last_item
//
//  Intake: one received byte per cycle while s_tready is high. A good frame
//  then drains its data bytes, each by a registered frame store read and
//  then an output load, and waits while m_tready is low; no input is taken
//  during the drain. A status result is loaded in the cycle its byte is accepted.
//  Reset: rst_n is asynchronous, active low; the frame store has no reset
//  and needs no clearing pass. Stalls: s_tready drops while the output
//  register holds an item that is not being taken in the same cycle.
//
module dlt645_frame_receiver #(
    parameter int BUFFER_BYTES = dlt_pkg::BUFFER_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // rx_byte[7:0]
    input  logic [7:0]                      s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // data_byte[7:0], byte_index[13:8], data_length[21:14],
    // control_code[29:22], meter_address[77:30], zero pad[79:78]
    output logic [dlt_pkg::OUT_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready
);
    import dlt_pkg::*;

    dlt_cmd_t  cmd;
    dlt_stat_t stat;
    logic      busy;

    // sequencer: intake, outcome decision and drain of data items
    dlt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    // storage, checksum, header capture and output register
    dlt_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (m_tuser),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );

    // no byte is taken while data items are draining
    a_no_intake_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_tready)
        else $error("input accepted during data drain");

    // data item is loaded only into an empty output register
    a_load_data_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_data |-> !m_tvalid)
        else $error("data load over a pending result");

    // status load never overwrites a result that is still held
    a_load_status_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_status |-> (!m_tvalid || m_tready))
        else $error("status load over a pending result");

    // only the final item of a frame may carry a non-ok status
    a_mid_items_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser == STATUS_OK))
        else $error("error status on a non-final item");

endmodule

// ----- verif/dlt645_rx_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dlt645_rx_checker
// Watches both stream channels of the frame receiver, decodes the accepted
// byte stream on its own and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module dlt645_rx_checker #(
    parameter int BUFFER_BYTES = dlt_pkg::BUFFER_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [7:0]                      s_tdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [dlt_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic [1:0]                      m_tuser,
    input  logic                            m_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    output int                              mismatches,
    output int                              pending
);
    import dlt_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  data;
        logic [5:0]  idx;
        logic [7:0]  len;
        logic [7:0]  ctrl;
        logic [47:0] addr;
        logic        last;
    } rx_result_t;

    logic [7:0] frame_mem [BUFFER_BYTES];
    logic [6:0] rx_count;
    logic [7:0] rx_sum;
    rx_result_t decoded_q [$];

    // header fields are taken from the frame as stored
    task automatic push_decoded(input logic [1:0] status, input logic [7:0] data,
                                input logic [5:0] idx, input logic last);
        rx_result_t r;
        r.status = status;
        r.data   = data;
        r.idx    = idx;
        r.len    = frame_mem[9];
        r.ctrl   = frame_mem[8];
        r.addr   = {frame_mem[6], frame_mem[5], frame_mem[4],
                    frame_mem[3], frame_mem[2], frame_mem[1]};
        r.last   = last;
        decoded_q.push_back(r);
    endtask

    task automatic decode_rx_byte(input logic [7:0] b);
        logic [8:0] frame_size;
        logic [7:0] cs_byte;
        logic [7:0] end_byte;
        logic [7:0] body_sum;
        int         n;
        int         i;
        if (rx_count == 0 && b != START_BYTE)
            return;
        if (rx_count < BUFFER_BYTES)
            frame_mem[rx_count] = b;
        rx_count = rx_count + 7'd1;
        rx_sum   = rx_sum + b;
        if (rx_count < HEADER_BYTES)
            return;

        frame_size = 9'(FRAME_OVERHEAD + frame_mem[9]);
        if (rx_count >= frame_size)
        begin
            cs_byte  = frame_mem[(frame_size - 2) % BUFFER_BYTES];
            end_byte = frame_mem[(frame_size - 1) % BUFFER_BYTES];
            body_sum = rx_sum - cs_byte - end_byte;
            // end marker is judged ahead of the checksum
            if (end_byte != END_BYTE)
                push_decoded(STATUS_BAD_END, 8'h00, 6'd0, 1'b1);
            else if (body_sum != cs_byte)
                push_decoded(STATUS_BAD_SUM, 8'h00, 6'd0, 1'b1);
            else if (frame_mem[9] == 8'h00)
                push_decoded(STATUS_OK, 8'h00, 6'd0, 1'b1);
            else
            begin
                n = (frame_mem[9] > MAX_RESULTS) ? MAX_RESULTS : frame_mem[9];
                for (i = 0; i < n; i++)
                    push_decoded(STATUS_OK,
                                 frame_mem[(HEADER_BYTES + i) % BUFFER_BYTES] - DATA_OFFSET,
                                 6'(i), i == n - 1);
            end
            rx_count = 7'd0;
            rx_sum   = 8'h00;
        end
        else if (rx_count >= BUFFER_BYTES)
        begin
            push_decoded(STATUS_OVERFLOW, 8'h00, 6'd0, 1'b1);
            rx_count = 7'd0;
            rx_sum   = 8'h00;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t checker: %s mismatch, expected %h actual %h",
                     $time, name, want, got);
        end
    endtask

    // Inputs only move right after a rising edge, so the levels seen at the
    // falling edge are the ones the next rising edge will act on.
    always @(negedge clk)
    begin
        rx_result_t want;
        if (!rst_n)
        begin
            rx_count   = 7'd0;
            rx_sum     = 8'h00;
            mismatches = 0;
            decoded_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (decoded_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t checker: unexpected result, expected none actual %h/%h/%b",
                             $time, m_tuser, m_tdata, m_tlast);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("status",        want.status, m_tuser);
                    check_field("data_byte",     want.data,   m_tdata[7:0]);
                    check_field("byte_index",    want.idx,    m_tdata[13:8]);
                    check_field("data_length",   want.len,    m_tdata[21:14]);
                    check_field("control_code",  want.ctrl,   m_tdata[29:22]);
                    check_field("meter_address", want.addr,   m_tdata[77:30]);
                    check_field("pad",           64'd0,       m_tdata[79:78]);
                    check_field("last_item",     want.last,   m_tlast);
                end
            end
            if (s_tvalid && s_tready)
                decode_rx_byte(s_tdata);
        end
        pending = decoded_q.size();
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Byte stimulus for the DL/T 645 frame receiver: directed frames covering
// every outcome, then random frames mixed with line noise, under random
// gaps and back-pressure. The checker judges results; this module decides.
// ----------------------------------------------------------------------------
module tb;
    import dlt_pkg::*;

    localparam int IDLE_LIMIT   = 4000;  // cycles without any transfer
    localparam int RANDOM_BYTES = 40;    // random phase, on top of ~195 directed
    localparam int TAIL_CYCLES  = 40;

    typedef enum {
        FRAME_GOOD,
        FRAME_BAD_END,
        FRAME_BAD_SUM,
        FRAME_BAD_BOTH,   // wrong end and wrong checksum: end must win
        FRAME_OVERFLOW,   // length too big for the buffer, send a full buffer
        FRAME_CUT         // stops early, the next bytes run into it
    } frame_kind_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic [7:0]             s_tdata  = 8'h00;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;

    logic quiet = 1'b0;        // no gaps, no stalls while set
    int   mismatches;
    int   pending;
    int   sent_bytes  = 0;
    int   idle_cycles = 0;

    always #1 clk = ~clk;

    dlt645_frame_receiver i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    dlt645_rx_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // receiver back-pressure, about a third of the cycles
    always @(posedge clk)
        m_tready <= rst_n && (quiet || $urandom_range(99) >= 33);

    function automatic bit take_gap();
        return !quiet && $urandom_range(99) < 33;
    endfunction

    // one byte transfer; s_tready is sampled mid-cycle, where it is settled
    task automatic send_byte(input logic [7:0] b);
        bit rdy;
        while (take_gap())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end while (!rdy);
        sent_bytes++;
    endtask

    // Builds 68 A0..A5 68 C L data.. CS 16 and sends all or part of it.
    // pin_ends puts raw 0x33 and 0x32 first, giving decoded 0x00 and 0xFF.
    task automatic send_frame(input frame_kind_t kind, input logic [7:0] len,
                              input logic [47:0] addr, input logic [7:0] ctrl,
                              input logic [7:0] second_start, input bit pin_ends);
        logic [7:0] fb [$];
        logic [7:0] cs;
        logic [7:0] end_b;
        int         keep;
        int         i;
        fb.push_back(START_BYTE);
        for (i = 0; i < 6; i++)
            fb.push_back(addr[8*i +: 8]);
        fb.push_back(second_start);    // stored, never checked
        fb.push_back(ctrl);
        fb.push_back(len);
        for (i = 0; i < len; i++)
        begin
            if (pin_ends && i == 0)
                fb.push_back(DATA_OFFSET);
            else if (pin_ends && i == 1)
                fb.push_back(DATA_OFFSET - 8'd1);
            else
                fb.push_back(8'($urandom));
        end
        cs = 8'h00;
        foreach (fb[k])
            cs += fb[k];
        if (kind == FRAME_BAD_SUM || kind == FRAME_BAD_BOTH)
            cs ^= 8'($urandom_range(255, 1));
        fb.push_back(cs);
        end_b = 8'($urandom);
        if (end_b == END_BYTE)
            end_b = ~END_BYTE;
        fb.push_back((kind == FRAME_BAD_END || kind == FRAME_BAD_BOTH) ? end_b : END_BYTE);

        keep = fb.size();
        if (kind == FRAME_OVERFLOW)
            keep = BUFFER_BYTES_DEF;
        else if (kind == FRAME_CUT)
            keep = $urandom_range(fb.size() - 1, 1);
        for (i = 0; i < keep; i++)
            send_byte(fb[i]);
    endtask

    // stall watchdog: ends the run when nothing moves for too long
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[dlt645_frame_receiver] ERROR");
        $finish;
    end

    initial
    begin
        int          roll;
        int          n;
        bit          paused;
        frame_kind_t kind;
        logic [7:0]  len;

        paused = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: line noise while hunting, then one frame per outcome
        send_byte(8'hFE);
        send_byte(8'hFE);
        send_byte(8'h00);
        send_byte(END_BYTE);
        send_frame(FRAME_GOOD,     8'd0,   48'h0,            8'h00, START_BYTE, 1'b0);
        send_frame(FRAME_GOOD,     8'd1,   48'hFFFFFFFFFFFF, 8'hFF, START_BYTE, 1'b0);
        // full-size data field, sent with no gaps and no stalls
        quiet = 1'b1;
        send_frame(FRAME_GOOD,     8'd52,  48'h123456789ABC, 8'h91, 8'h00,      1'b1);
        quiet = 1'b0;
        send_frame(FRAME_BAD_END,  8'd2,   48'h5A5A5A5A5A5A, 8'h13, START_BYTE, 1'b0);
        send_frame(FRAME_BAD_SUM,  8'd0,   48'h000000000001, 8'h14, START_BYTE, 1'b0);
        send_frame(FRAME_BAD_BOTH, 8'd0,   48'h800000000000, 8'h1C, START_BYTE, 1'b0);
        send_frame(FRAME_OVERFLOW, 8'd255, 48'hF0F0F0F0F0F0, 8'h03, START_BYTE, 1'b0);

        // ---- random: mostly well-formed frames, some broken ones and noise
        sent_bytes = 0;
        while (sent_bytes < RANDOM_BYTES)
        begin
            // hold the line until the receiver has drained everything
            if (!paused && sent_bytes >= 12)
            begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
            end

            if ($urandom_range(99) < 15)
            begin
                n = $urandom_range(4, 1);
                repeat (n)
                    send_byte(($urandom_range(99) < 60) ? 8'hFE : 8'($urandom));
            end

            roll = $urandom_range(99);
            if (roll < 70)
                kind = FRAME_GOOD;
            else if (roll < 78)
                kind = FRAME_BAD_END;
            else if (roll < 86)
                kind = FRAME_BAD_SUM;
            else if (roll < 90)
                kind = FRAME_BAD_BOTH;
            else if (roll < 95)
                kind = FRAME_OVERFLOW;
            else
                kind = FRAME_CUT;

            roll = $urandom_range(99);
            if (kind == FRAME_OVERFLOW)
                len = 8'($urandom_range(255, 53));
            else if (roll < 70)
                len = 8'($urandom_range(6));
            else if (roll < 95)
                len = 8'($urandom_range(20, 7));
            else
                len = 8'($urandom_range(52, 21));

            send_frame(kind, len, {16'($urandom), 32'($urandom)}, 8'($urandom),
                       ($urandom_range(99) < 90) ? START_BYTE : 8'($urandom),
                       1'b0);
        end

        // ---- drain, then let the output settle
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("[dlt645_frame_receiver] OK");
        else
            $display("[dlt645_frame_receiver] ERROR");
        $finish;
    end

endmodule
